// ----- hdl/tpaf_pkg.sv -----
// ----------------------------------------------------------------------------
// tpaf_pkg
// Shared constants and types of the triac phase-angle firing core.
// ----------------------------------------------------------------------------
package tpaf_pkg;

  // stream payload widths, whole bytes
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 40;

  // delay code that disables firing
  localparam logic [15:0] NEVER_FIRE = 16'hFFFF;

  // pulse length after reset, and the end compare that goes with it
  localparam logic [15:0] PULSE_LEN_RST = 16'd100;
  localparam logic [15:0] END_CMP_RST   = NEVER_FIRE + PULSE_LEN_RST;

  // one result item
  typedef struct packed {
    logic        period_new;
    logic [15:0] zero_len;
    logic [15:0] period;
    logic        gate_n;
  } tpaf_result_t;

endpackage

// ----- hdl/tpaf_firing_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpaf_firing_ctrl
// Tick counter, period and zero-interval capture, gate compare logic.
// State advances by one tick on each step; result shows the updated state.
// ----------------------------------------------------------------------------
module tpaf_firing_ctrl #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  zc_rise_i,
  input  logic                  zc_fall_i,
  input  logic [15:0]           fire_delay_i,
  input  logic [15:0]           pulse_len_i,
  output tpaf_pkg::tpaf_result_t result_o
);
  import tpaf_pkg::*;

  localparam int unsigned XW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] period_q, period_d;
  logic [COUNT_WIDTH-1:0] zlen_q, zlen_d;
  logic [15:0]            start_q, start_d;
  logic [15:0]            end_q, end_d;
  logic                   gate_q, gate_d;
  logic [COUNT_WIDTH-1:0] cnt_eff;
  logic [16:0]            fire_end;
  logic                   fire_ok;

  // next state for one tick, in the order of the firing rules
  always_comb begin
    cnt_eff  = cnt_q;
    period_d = period_q;
    zlen_d   = zlen_q;
    start_d  = start_q;
    end_d    = end_q;
    gate_d   = gate_q;
    // rising edge: capture period, restart counter, latch compares
    if (zc_rise_i) begin
      period_d = cnt_q;
      start_d  = fire_delay_i;
      end_d    = fire_delay_i + pulse_len_i;
      gate_d   = 1'b1;
      cnt_eff  = '0;
    end
    // falling edge: capture near-zero interval
    if (zc_fall_i) begin
      zlen_d = cnt_eff;
    end
    // start compare, only if the pulse ends inside the half-cycle
    fire_end = {1'b0, start_d} + {1'b0, pulse_len_i};
    fire_ok  = (XW'(cnt_eff) == XW'(start_d)) && (start_d != NEVER_FIRE) &&
               ((XW+1)'(fire_end) < (XW+1)'(period_d));
    if (fire_ok) begin
      gate_d = 1'b0;
    end
    // end compare wins over start
    if (XW'(cnt_eff) == XW'(end_d)) begin
      gate_d = 1'b1;
    end
    // counter overflow: no mains
    if (cnt_eff == CntMax) begin
      period_d = '0;
      start_d  = NEVER_FIRE;
      end_d    = NEVER_FIRE + pulse_len_i;
      gate_d   = 1'b1;
      cnt_d    = '0;
    end else begin
      cnt_d = cnt_eff + 1'b1;
    end
  end

  // result fields show the low 16 bits of the captures
  always_comb begin
    result_o.gate_n     = gate_d;
    result_o.period     = 16'(XW'(period_d));
    result_o.zero_len   = 16'(XW'(zlen_d));
    result_o.period_new = zc_rise_i;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      period_q <= '0;
      zlen_q   <= '0;
      start_q  <= NEVER_FIRE;
      end_q    <= END_CMP_RST;
      gate_q   <= 1'b1;
    end else if (step_i) begin
      cnt_q    <= cnt_d;
      period_q <= period_d;
      zlen_q   <= zlen_d;
      start_q  <= start_d;
      end_q    <= end_d;
      gate_q   <= gate_d;
    end
  end

`ifndef SYNTHESIS
  // a rising edge restarts the count, so the next tick sees one
  a_rise_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && zc_rise_i |=> cnt_q == COUNT_WIDTH'(1))
    else $error("counter not restarted by rising edge");

  // overflow without an edge clears the period and disables firing
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !zc_rise_i && cnt_q == CntMax |=>
    period_q == '0 && start_q == NEVER_FIRE && gate_q && cnt_q == '0)
    else $error("overflow did not clear period and compares");

  // an active gate always belongs to an enabled delay
  a_gate_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !gate_q |-> start_q != NEVER_FIRE)
    else $error("gate active with firing disabled");
`endif

endmodule

// ----- hdl/triac_phase_angle_firing_core.sv -----
// ----------------------------------------------------------------------------
// triac_phase_angle_firing_core
// Phase-angle firing of a triac gate from mains zero-crossing edges.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one transfer per prescaled timer tick with the zero-crossing
//   edge flags and the firing delay. Each accepted tick advances the counter
//   and yields exactly one result transfer on m_axis: gate drive, period,
//   near-zero interval length and a period-captured flag.
//   cfg_* writes the gate pulse length; it is always ready and should be
//   written only while no tick is in flight.
// Timing and throughput:
//   a result is registered and appears in the cycle after its tick is accepted;
//   one tick per cycle is sustained while m_axis_tready is high, limited by
//   the single state-update stage between input handshake and output register.
// Stall:
//   s_axis_tready stays high while the output register is empty or its result
//   is being taken in the same cycle; a stalled receiver holds the result and
//   backs up the input after one tick.
// Reset:
//   counter, period and interval clear, firing is disabled, gate is idle and
//   the pulse length returns to 100 ticks.
// ----------------------------------------------------------------------------
module triac_phase_angle_firing_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration: pulse_len
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [15:0]                    cfg_data_i,
  // tick input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] zc_rise, [1] zc_fall, [17:2] fire_delay, [23:18] zero
  input  logic [tpaf_pkg::InTdataW-1:0]  s_axis_tdata,
  // result output
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] gate_n, [16:1] period, [32:17] zero_len, [33] period_new, [39:34] zero
  output logic [tpaf_pkg::OutTdataW-1:0] m_axis_tdata
);
  import tpaf_pkg::*;

  logic         in_xfer;
  logic [15:0]  pulse_len_q;
  logic         m_valid_q;
  tpaf_result_t res_d;
  tpaf_result_t res_q;

  // input accepted while the output register frees up
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // pulse length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_len_q <= PULSE_LEN_RST;
    end else if (cfg_valid_i) begin
      pulse_len_q <= cfg_data_i;
    end
  end

  tpaf_firing_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_xfer),
    .zc_rise_i    (s_axis_tdata[0]),
    .zc_fall_i    (s_axis_tdata[1]),
    .fire_delay_i (s_axis_tdata[17:2]),
    .pulse_len_i  (pulse_len_q),
    .result_o     (res_d)
  );

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (in_xfer) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, res_q};

endmodule

// ----- dv/tpaf_firing_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpaf_firing_checker
// Watches the tick, result and pulse-length channels of the firing core, runs
// its own model of the counter, captures and gate compares on every accepted
// tick, and compares each result transfer field by field with the oldest
// predicted result. Hands the failure count and the number of outstanding
// results to the testbench top.
// ----------------------------------------------------------------------------
module tpaf_firing_checker
  import tpaf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [InTdataW-1:0]   s_tdata_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OutTdataW-1:0]  m_tdata_i,
  output int unsigned           pending_o,
  output int unsigned           fail_cnt_o
);

  localparam int unsigned ReportMax = 10;
  localparam logic [15:0] CountMax  = 16'hFFFF;

  // model state
  logic [15:0] tick_cnt;
  logic [15:0] period_q;
  logic [15:0] zlen_q;
  logic [15:0] start_cmp_q;
  logic [15:0] end_cmp_q;
  logic        gate_q;
  logic [15:0] pulse_q;

  tpaf_result_t result_due_q[$];
  int unsigned  fail_cnt;

  // one tick of the firing controller, returns the result it yields
  function automatic tpaf_result_t advance_tick(logic rise, logic fall, logic [15:0] delay);
    tpaf_result_t res;
    logic [15:0]  c;
    logic         captured;
    c        = tick_cnt;
    captured = 1'b0;
    // rising edge: capture period, restart, latch compares, gate idle
    if (rise) begin
      period_q    = c;
      start_cmp_q = delay;
      end_cmp_q   = delay + pulse_q;
      gate_q      = 1'b1;
      captured    = 1'b1;
      c           = '0;
    end
    if (fall) begin
      zlen_q = c;
    end
    // start compare, firing allowed only if the whole pulse fits the period
    if (c == start_cmp_q && start_cmp_q != NEVER_FIRE &&
        ({1'b0, start_cmp_q} + {1'b0, pulse_q}) < {1'b0, period_q}) begin
      gate_q = 1'b0;
    end
    // end compare wins over start
    if (c == end_cmp_q) begin
      gate_q = 1'b1;
    end
    // overflow means no mains
    if (c == CountMax) begin
      period_q    = '0;
      start_cmp_q = NEVER_FIRE;
      end_cmp_q   = NEVER_FIRE + pulse_q;
      gate_q      = 1'b1;
      tick_cnt    = '0;
    end else begin
      tick_cnt = c + 16'd1;
    end
    res.gate_n     = gate_q;
    res.period     = period_q;
    res.zero_len   = zlen_q;
    res.period_new = captured;
    return res;
  endfunction

  task automatic report_bad(string what, tpaf_result_t exp_r, logic [OutTdataW-1:0] act);
    tpaf_result_t act_r;
    act_r = act[$bits(tpaf_result_t)-1:0];
    fail_cnt++;
    if (fail_cnt <= ReportMax) begin
      $display("%0t: %s exp gate_n=%0b period=%0d zero_len=%0d period_new=%0b",
               $realtime, what, exp_r.gate_n, exp_r.period, exp_r.zero_len,
               exp_r.period_new);
      $display("%0t:    act gate_n=%0b period=%0d zero_len=%0d period_new=%0b pad=%0h",
               $realtime, act_r.gate_n, act_r.period, act_r.zero_len,
               act_r.period_new, act[OutTdataW-1:$bits(tpaf_result_t)]);
    end
  endtask

  // channel monitor, results are popped before the tick of this edge is pushed
  always @(posedge clk_i or negedge rst_ni) begin
    tpaf_result_t exp_r;
    tpaf_result_t act_r;
    if (!rst_ni) begin
      tick_cnt    = '0;
      period_q    = '0;
      zlen_q      = '0;
      start_cmp_q = NEVER_FIRE;
      end_cmp_q   = END_CMP_RST;
      gate_q      = 1'b1;
      pulse_q     = PULSE_LEN_RST;
      result_due_q.delete();
      fail_cnt    = 0;
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      // result transfer
      if (m_tvalid_i && m_tready_i) begin
        if (result_due_q.size() == 0) begin
          exp_r = '0;
          report_bad("unexpected result", exp_r, m_tdata_i);
        end else begin
          exp_r = result_due_q.pop_front();
          act_r = m_tdata_i[$bits(tpaf_result_t)-1:0];
          if (act_r.gate_n !== exp_r.gate_n || act_r.period !== exp_r.period ||
              act_r.zero_len !== exp_r.zero_len ||
              act_r.period_new !== exp_r.period_new ||
              m_tdata_i[OutTdataW-1:$bits(tpaf_result_t)] !== '0) begin
            report_bad("result mismatch", exp_r, m_tdata_i);
          end
        end
      end
      // tick transfer
      if (s_tvalid_i && s_tready_i) begin
        result_due_q.push_back(advance_tick(s_tdata_i[0], s_tdata_i[1], s_tdata_i[17:2]));
      end
      // pulse length write
      if (cfg_valid_i && cfg_ready_i) begin
        pulse_q = cfg_data_i;
      end
      pending_o  <= result_due_q.size();
      fail_cnt_o <= fail_cnt;
    end
  end

endmodule

// ----- dv/tb_triac_phase_angle_firing_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triac_phase_angle_firing_core
// Drives zero-crossing ticks into the firing core: a few directed ticks, then
// mains-like half-cycles with random firing delays over a range of pulse
// lengths, with noise ticks in between.
// Both stream sides stall in random bursts; the checker beside the core
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_triac_phase_angle_firing_core;
  import tpaf_pkg::*;

  localparam int unsigned IdleLimit = 2000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [15:0]          cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  int unsigned pending;
  int unsigned fail_cnt;
  bit          src_idle_en = 1'b1;
  bit          dst_idle_en = 1'b1;
  int unsigned dst_stall_left = 0;

  triac_phase_angle_firing_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tpaf_firing_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .pending_o   (pending),
    .fail_cnt_o  (fail_cnt)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result receiver with random stall bursts
  always @(posedge clk_i) begin
    if (dst_stall_left > 0) begin
      dst_stall_left <= dst_stall_left - 1;
      m_axis_tready  <= 1'b0;
    end else if (dst_idle_en && $urandom_range(0, 7) == 0) begin
      dst_stall_left <= $urandom_range(1, 18) - 1;
      m_axis_tready  <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // one tick transfer, with an optional gap in front of it
  task automatic send_tick(logic rise, logic fall, logic [15:0] delay);
    if (src_idle_en && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, delay, fall, rise};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // hold the ticks back until every result is in
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_pulse_len(logic [15:0] len);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // rising edge, then per-1 ticks with the near-zero interval ending somewhere
  task automatic mains_half_cycle(int per, int pulse);
    int          fall_at;
    int          room;
    logic [15:0] delay;
    room = (per > pulse) ? per - pulse : 0;
    case ($urandom_range(0, 9))
      0:       delay = NEVER_FIRE;
      1:       delay = 16'($urandom);
      2:       delay = 16'(room);
      3:       delay = 16'(room - 1);
      default: delay = 16'($urandom_range(0, room));
    endcase
    fall_at = int'($urandom_range(0, per / 3 + 1));
    send_tick(1'b1, fall_at == 0, delay);
    for (int i = 1; i < per; i++) begin
      send_tick(1'b0, i == fall_at || $urandom_range(0, 40) == 0, 16'($urandom));
    end
  endtask

  // a run of half-cycles at one pulse length, entered mid half-cycle
  task automatic pulse_phase(logic [15:0] pulse, int halves);
    int base;
    int per;
    write_pulse_len(pulse);
    base = (pulse <= 120) ? int'(pulse) + int'($urandom_range(4, 20)) :
                            int'($urandom_range(4, 20));
    // old end compare still latched, new pulse length in the firing test
    repeat ($urandom_range(0, base)) send_tick(1'b0, 1'b0, 16'($urandom));
    for (int h = 0; h < halves; h++) begin
      if ($urandom_range(0, 7) == 0) begin
        // noise ticks
        repeat ($urandom_range(1, 6)) begin
          send_tick(1'($urandom), 1'($urandom), 16'($urandom));
        end
      end
      per = base + int'($urandom_range(0, 4)) - 2;
      mains_half_cycle((per < 2) ? 2 : per, pulse);
    end
  endtask

  // stimulus
  initial begin
    logic [15:0] pulse_set[6];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: flag combinations and delay extremes at the reset pulse length
    send_tick(1'b0, 1'b0, 16'h0000);
    send_tick(1'b1, 1'b0, NEVER_FIRE);
    send_tick(1'b0, 1'b1, 16'h0000);
    send_tick(1'b1, 1'b1, 16'h0000);
    send_tick(1'b0, 1'b0, NEVER_FIRE);
    send_tick(1'b1, 1'b0, 16'hAAAA);
    send_tick(1'b0, 1'b1, 16'h5555);
    send_tick(1'b1, 1'b0, 16'h0002);
    repeat (4) send_tick(1'b0, 1'b0, 16'h0000);
    send_tick(1'b1, 1'b1, 16'hFFFE);
    send_tick(1'b0, 1'b0, 16'h0001);

    // pulse lengths, zero and the full range among them
    pulse_set = '{16'd1, 16'd0, 16'd3, 16'd17, 16'hFFFF,
                  16'($urandom_range(2, 40))};
    foreach (pulse_set[k]) begin
      pulse_phase(pulse_set[k], int'($urandom_range(2, 3)));
    end

    // closing phase, no stalls
    src_idle_en = 1'b0;
    dst_idle_en = 1'b0;
    pulse_phase(16'($urandom_range(1, 30)), 2);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/tpaf_pkg.sv
hdl/tpaf_firing_ctrl.sv
hdl/triac_phase_angle_firing_core.sv
dv/tpaf_firing_checker.sv
dv/tb_triac_phase_angle_firing_core.sv
